// File: rtl/hwcs_pkg.sv
// ----------------------------------------------------------------------------
// hwcs_pkg
// shared widths, limits and status codes of the hardy-weinberg chi-square block
// ----------------------------------------------------------------------------
package hwcs_pkg;

    // genotype count width
    localparam int CountBits = 20;
    // total of three counts
    localparam int TotalW    = CountBits + 2;
    // allele counts 2*hom + het
    localparam int AlleleW   = CountBits + 2;
    // allele frequency, unsigned q0.16 with room for 1.0
    localparam int FreqW     = 17;
    // expected counts and chi-square in q.8
    localparam int ExpW      = TotalW + 8;
    // allele count products
    localparam int ProdW     = 2 * AlleleW;
    // first division numerator: 128*a*b is the widest
    localparam int Div1NumW  = ProdW + 7;
    // second division numerator: squared deviation
    localparam int Div2NumW  = 2 * ExpW;
    // quotient bits of every division
    localparam int QuoW      = ExpW;

    localparam logic [ExpW-1:0]  ChiMax  = {ExpW{1'b1}};
    localparam logic [FreqW-1:0] FreqOne = FreqW'(65536);

    typedef enum logic [1:0] {
        StOk      = 2'd0,
        StEmpty   = 2'd1,
        StZeroExp = 2'd2
    } t_status;

endpackage

// File: rtl/hwcs_if.sv
// ----------------------------------------------------------------------------
// hwcs_in_if / hwcs_res_if
// valid/ready channels carrying genotype counts in and test results out
// ----------------------------------------------------------------------------
interface hwcs_in_if;
    logic                           valid;
    logic                           ready;
    logic [hwcs_pkg::CountBits-1:0] count_hom_major;
    logic [hwcs_pkg::CountBits-1:0] count_het;
    logic [hwcs_pkg::CountBits-1:0] count_hom_minor;

    modport source (output valid, output count_hom_major, output count_het,
                    output count_hom_minor, input ready);
    modport sink   (input valid, input count_hom_major, input count_het,
                    input count_hom_minor, output ready);
endinterface

interface hwcs_res_if;
    logic                        valid;
    logic                        ready;
    logic [hwcs_pkg::TotalW-1:0] total_count;
    logic [hwcs_pkg::FreqW-1:0]  freq_major;
    logic [hwcs_pkg::FreqW-1:0]  freq_minor;
    logic [hwcs_pkg::ExpW-1:0]   expect_hom_major;
    logic [hwcs_pkg::ExpW-1:0]   expect_het;
    logic [hwcs_pkg::ExpW-1:0]   expect_hom_minor;
    logic [hwcs_pkg::ExpW-1:0]   chi_square;
    logic [1:0]                  status;

    modport source (output valid, output total_count, output freq_major,
                    output freq_minor, output expect_hom_major, output expect_het,
                    output expect_hom_minor, output chi_square, output status,
                    input ready);
    modport sink   (input valid, input total_count, input freq_major,
                    input freq_minor, input expect_hom_major, input expect_het,
                    input expect_hom_minor, input chi_square, input status,
                    output ready);
endinterface

// File: rtl/hwcs_div.sv
// ----------------------------------------------------------------------------
// hwcs_div
// pipelined restoring divider, several lanes, one quotient bit per stage
// ----------------------------------------------------------------------------
module hwcs_div #(
    parameter int LANES = 1,
    parameter int NUM_W = 8,
    parameter int DEN_W = 4,
    parameter int Q_W   = 4,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num [LANES],
    input  logic [DEN_W-1:0] i_den [LANES],
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo [LANES],
    output logic [SB_W-1:0]  o_sb
);

    // quotient must be below 2**Q_W, so the upper numerator part is below den
    logic [DEN_W-1:0] r_rem [Q_W+1][LANES];
    logic [Q_W-1:0]   r_low [Q_W+1][LANES];
    logic [DEN_W-1:0] r_den [Q_W+1][LANES];
    logic [SB_W-1:0]  r_sb  [Q_W+1];
    logic [Q_W:0]     r_v;

    logic [DEN_W-1:0] n_rem [Q_W+1][LANES];
    logic [Q_W-1:0]   n_low [Q_W+1][LANES];
    logic [DEN_W-1:0] n_den [Q_W+1][LANES];
    logic [SB_W-1:0]  n_sb  [Q_W+1];

    always_comb begin
        logic [DEN_W:0] t;
        logic           ge;
        for (int l = 0; l < LANES; l++) begin
            n_rem[0][l] = DEN_W'(i_num[l] >> Q_W);
            n_low[0][l] = i_num[l][Q_W-1:0];
            n_den[0][l] = i_den[l];
        end
        n_sb[0] = i_sb;
        for (int s = 1; s <= Q_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
                t  = {r_rem[s-1][l], r_low[s-1][l][Q_W-1]};
                ge = (t >= {1'b0, r_den[s-1][l]});
                n_rem[s][l] = ge ? DEN_W'(t - {1'b0, r_den[s-1][l]}) : DEN_W'(t);
                n_low[s][l] = {r_low[s-1][l][Q_W-2:0], ge};
                n_den[s][l] = r_den[s-1][l];
            end
            n_sb[s] = r_sb[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Q_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_den <= n_den;
            r_sb  <= n_sb;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_low[Q_W][l];
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_sb    = r_sb[Q_W];

endmodule

// File: rtl/hardy_weinberg_chi_square.sv
// ----------------------------------------------------------------------------
// hardy_weinberg_chi_square
// hardy-weinberg equilibrium chi-square test, one marker per transfer
// ----------------------------------------------------------------------------
// Takes one count triple per clock while the output is not stalled, and
// returns one result per triple, in order. The pipe is 67 register stages
// deep. Most of the latency comes from two
// restoring dividers in series. Each divider is 31 register stages: an
// operand register, then one quotient bit per stage for 30 bits. The first
// divides by the total to give p and the three expected counts. The second
// divides each squared deviation by its expected count. The remaining stages
// are input registers, the allele products, the deviation, its square and the
// output register. The whole pipe advances together. A stalled result holds
// every stage, so ready follows the output side combinationally. Status is
// empty for a zero total (all other fields zero). It also flags any genotype
// whose expected count is zero, which then drops out of the sum. chi_square
// saturates at 2**30-1.
// ----------------------------------------------------------------------------
module hardy_weinberg_chi_square (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hwcs_in_if.sink    i_in,
    hwcs_res_if.source o_res
);

    localparam int CB  = hwcs_pkg::CountBits;
    localparam int TW  = hwcs_pkg::TotalW;
    localparam int AW  = hwcs_pkg::AlleleW;
    localparam int PW  = hwcs_pkg::ProdW;
    localparam int EW  = hwcs_pkg::ExpW;
    localparam int FW  = hwcs_pkg::FreqW;
    localparam int N1W = hwcs_pkg::Div1NumW;
    localparam int N2W = hwcs_pkg::Div2NumW;
    localparam int QW  = hwcs_pkg::QuoW;
    localparam int SB1 = 3 * CB + TW;
    localparam int SB2 = 6 + 3 * EW + FW + TW;

    // global advance: the pipe moves unless a result sits untaken
    logic r_ov;
    logic w_adv;
    assign w_adv      = !r_ov || o_res.ready;
    assign i_in.ready = w_adv;

    // stage 1: capture counts, total and allele counts
    logic          r_v1;
    logic [CB-1:0] r1_c [3];
    logic [TW-1:0] r1_n;
    logic [AW-1:0] r1_a, r1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_c[0] <= i_in.count_hom_major;
            r1_c[1] <= i_in.count_het;
            r1_c[2] <= i_in.count_hom_minor;
            r1_n    <= TW'(i_in.count_hom_major) + TW'(i_in.count_het)
                     + TW'(i_in.count_hom_minor);
            r1_a    <= {1'b0, i_in.count_hom_major, 1'b0} + AW'(i_in.count_het);
            r1_b    <= {1'b0, i_in.count_hom_minor, 1'b0} + AW'(i_in.count_het);
        end
    end

    // stage 2: allele products
    logic          r_v2;
    logic [CB-1:0] r2_c [3];
    logic [TW-1:0] r2_n;
    logic [AW-1:0] r2_a;
    logic [PW-1:0] r2_aa, r2_ab, r2_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_c  <= r1_c;
            r2_n  <= r1_n;
            r2_a  <= r1_a;
            r2_aa <= r1_a * r1_a;
            r2_ab <= r1_a * r1_b;
            r2_bb <= r1_b * r1_b;
        end
    end

    // first divider: p, expected hom major, het, hom minor, all over the total
    logic [N1W-1:0] w_num1 [4];
    logic [TW-1:0]  w_den1 [4];
    logic           w_v1o;
    logic [QW-1:0]  w_quo1 [4];
    logic [SB1-1:0] w_sb1o;

    always_comb begin
        w_num1[0] = N1W'({r2_a, 15'd0});
        w_num1[1] = N1W'({r2_aa, 6'd0});
        w_num1[2] = N1W'({r2_ab, 7'd0});
        w_num1[3] = N1W'({r2_bb, 6'd0});
        for (int l = 0; l < 4; l++) begin
            w_den1[l] = r2_n;
        end
    end

    hwcs_div #(
        .LANES (4),
        .NUM_W (N1W),
        .DEN_W (TW),
        .Q_W   (QW),
        .SB_W  (SB1)
    ) u_div_freq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_v2),
        .i_num   (w_num1),
        .i_den   (w_den1),
        .i_sb    ({r2_c[0], r2_c[1], r2_c[2], r2_n}),
        .o_valid (w_v1o),
        .o_quo   (w_quo1),
        .o_sb    (w_sb1o)
    );

    // stage 3: absolute deviation of scaled observed from expected
    logic          r_v3;
    logic [EW-1:0] r3_d [3];
    logic [EW-1:0] r3_e [3];
    logic [FW-1:0] r3_p;
    logic [TW-1:0] r3_n;
    logic [CB-1:0] w_obs [3];
    logic [EW-1:0] w_o8  [3];

    assign w_obs[0] = w_sb1o[TW+3*CB-1 -: CB];
    assign w_obs[1] = w_sb1o[TW+2*CB-1 -: CB];
    assign w_obs[2] = w_sb1o[TW+CB-1 -: CB];

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            w_o8[g] = EW'({w_obs[g], 8'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= w_v1o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int g = 0; g < 3; g++) begin
                r3_e[g] <= w_quo1[g+1];
                r3_d[g] <= (w_o8[g] >= w_quo1[g+1]) ? w_o8[g] - w_quo1[g+1]
                                                    : w_quo1[g+1] - w_o8[g];
            end
            r3_p <= w_quo1[0][FW-1:0];
            r3_n <= w_sb1o[TW-1:0];
        end
    end

    // stage 4: squared deviation
    logic           r_v4;
    logic [N2W-1:0] r4_sq [3];
    logic [EW-1:0]  r4_e  [3];
    logic [FW-1:0]  r4_p;
    logic [TW-1:0]  r4_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int g = 0; g < 3; g++) begin
                r4_sq[g] <= r3_d[g] * r3_d[g];
            end
            r4_e <= r3_e;
            r4_p <= r3_p;
            r4_n <= r3_n;
        end
    end

    // second divider: each term over its expected count; a quotient that
    // would not fit is flagged as saturated, a zero expected count as dropped
    logic [2:0]     w_sat, w_zero;
    logic [N2W-1:0] w_num2 [3];
    logic [EW-1:0]  w_den2 [3];
    logic           w_v2o;
    logic [QW-1:0]  w_quo2 [3];
    logic [SB2-1:0] w_sb2o;

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            w_zero[g] = (r4_e[g] == '0);
            w_sat[g]  = (r4_sq[g][N2W-1:QW] >= r4_e[g]);
            w_num2[g] = (w_zero[g] || w_sat[g]) ? '0 : r4_sq[g];
            w_den2[g] = r4_e[g];
        end
    end

    hwcs_div #(
        .LANES (3),
        .NUM_W (N2W),
        .DEN_W (EW),
        .Q_W   (QW),
        .SB_W  (SB2)
    ) u_div_chi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_v4),
        .i_num   (w_num2),
        .i_den   (w_den2),
        .i_sb    ({w_zero, w_sat, r4_e[0], r4_e[1], r4_e[2], r4_p, r4_n}),
        .o_valid (w_v2o),
        .o_quo   (w_quo2),
        .o_sb    (w_sb2o)
    );

    // output stage: sum with saturation, status, output register
    logic [2:0]    w_zero_o, w_sat_o;
    logic [EW-1:0] w_e_o [3];
    logic [FW-1:0] w_p_o;
    logic [TW-1:0] w_n_o;
    logic [EW-1:0] w_term [3];
    logic [EW+1:0] w_sum;
    logic          w_empty;

    assign w_zero_o = w_sb2o[SB2-1 -: 3];
    assign w_sat_o  = w_sb2o[SB2-4 -: 3];
    assign w_e_o[0] = w_sb2o[TW+FW+3*EW-1 -: EW];
    assign w_e_o[1] = w_sb2o[TW+FW+2*EW-1 -: EW];
    assign w_e_o[2] = w_sb2o[TW+FW+EW-1 -: EW];
    assign w_p_o    = w_sb2o[TW+FW-1 -: FW];
    assign w_n_o    = w_sb2o[TW-1:0];
    assign w_empty  = (w_n_o == '0);

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            w_term[g] = w_zero_o[g] ? '0 : (w_sat_o[g] ? hwcs_pkg::ChiMax : w_quo2[g]);
        end
        w_sum = (EW+2)'(w_term[0]) + (EW+2)'(w_term[1]) + (EW+2)'(w_term[2]);
    end

    logic [TW-1:0] r_o_n;
    logic [FW-1:0] r_o_p, r_o_q;
    logic [EW-1:0] r_o_e [3];
    logic [EW-1:0] r_o_chi;
    logic [1:0]    r_o_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= w_v2o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_empty) begin
                r_o_n   <= '0;
                r_o_p   <= '0;
                r_o_q   <= '0;
                r_o_e   <= '{default: '0};
                r_o_chi <= '0;
                r_o_st  <= hwcs_pkg::StEmpty;
            end else begin
                r_o_n   <= w_n_o;
                r_o_p   <= w_p_o;
                r_o_q   <= hwcs_pkg::FreqOne - w_p_o;
                r_o_e   <= w_e_o;
                r_o_chi <= (w_sum > (EW+2)'(hwcs_pkg::ChiMax)) ? hwcs_pkg::ChiMax
                                                              : w_sum[EW-1:0];
                r_o_st  <= (w_zero_o != '0) ? hwcs_pkg::StZeroExp : hwcs_pkg::StOk;
            end
        end
    end

    assign o_res.valid            = r_ov;
    assign o_res.total_count      = r_o_n;
    assign o_res.freq_major       = r_o_p;
    assign o_res.freq_minor       = r_o_q;
    assign o_res.expect_hom_major = r_o_e[0];
    assign o_res.expect_het       = r_o_e[1];
    assign o_res.expect_hom_minor = r_o_e[2];
    assign o_res.chi_square       = r_o_chi;
    assign o_res.status           = r_o_st;

endmodule

// File: rtl/hwcs_checker.sv
// ----------------------------------------------------------------------------
// hwcs_checker
// port-level checks on the hardy-weinberg chi-square results
// ----------------------------------------------------------------------------
module hwcs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [hwcs_pkg::TotalW-1:0] i_total_count,
    input logic [hwcs_pkg::FreqW-1:0]  i_freq_major,
    input logic [hwcs_pkg::FreqW-1:0]  i_freq_minor,
    input logic [hwcs_pkg::ExpW-1:0]   i_chi_square,
    input logic [1:0]                  i_status
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    // empty status exactly when the total is zero, with frequencies and chi-square cleared
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_status == hwcs_pkg::StEmpty) == (i_total_count == '0)) &&
                    ((i_status != hwcs_pkg::StEmpty) ||
                     (i_freq_major == '0 && i_freq_minor == '0 && i_chi_square == '0)))
        else $error("empty status mismatch");

    // allele frequencies sum to one for a nonzero total
    a_freq_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != hwcs_pkg::StEmpty |->
            ({1'b0, i_freq_major} + {1'b0, i_freq_minor}) == (hwcs_pkg::FreqW+1)'(65536))
        else $error("allele frequencies do not sum to one");

    // a stalled result stays valid and keeps its chi-square and status
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_chi_square) && $stable(i_status))
        else $error("stalled result changed");

endmodule

bind hardy_weinberg_chi_square hwcs_checker u_hwcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_total_count (o_res.total_count),
    .i_freq_major  (o_res.freq_major),
    .i_freq_minor  (o_res.freq_minor),
    .i_chi_square  (o_res.chi_square),
    .i_status      (o_res.status)
);

// File: tb/hardy_weinberg_chi_square_test.sv
// ----------------------------------------------------------------------------
// hardy_weinberg_chi_square_test
// streams genotype count triples through the block and checks every result
// ----------------------------------------------------------------------------
// A scoreboard class computes the expected total, allele frequencies,
// expected genotype counts and chi-square sum for each accepted triple and
// compares the block's results in order. Stimulus starts with directed
// corner cases (zero total, monomorphic markers, full-scale counts), then
// random triples of mixed magnitude. Both sides pause at random, and the
// result side holds off once for a long stretch so the pipe fills up.
// ----------------------------------------------------------------------------
module hardy_weinberg_chi_square_test;

    localparam int CountBits = hwcs_pkg::CountBits;
    localparam int TotalW    = hwcs_pkg::TotalW;
    localparam int FreqW     = hwcs_pkg::FreqW;
    localparam int ExpW      = hwcs_pkg::ExpW;

    typedef struct packed {
        logic [TotalW-1:0] total;
        logic [FreqW-1:0]  p;
        logic [FreqW-1:0]  q;
        logic [ExpW-1:0]   e_aa;
        logic [ExpW-1:0]   e_het;
        logic [ExpW-1:0]   e_bb;
        logic [ExpW-1:0]   chi;
        logic [1:0]        status;
    } t_hw_result;

    class hw_scoreboard;
        t_hw_result pending[$];
        int         mismatches;

        // one genotype's contribution; zero expected count drops the term
        function logic [63:0] chi_term(logic [63:0] obs, logic [63:0] e,
                                       ref bit zero_seen);
            logic [63:0] o8;
            logic [63:0] d;
            o8 = obs << 8;
            if (e == 0) begin
                zero_seen = 1;
                return 0;
            end
            d = (o8 >= e) ? o8 - e : e - o8;
            return (d * d) / e;
        endfunction

        function void note_counts(logic [CountBits-1:0] aa, logic [CountBits-1:0] het,
                                  logic [CountBits-1:0] bb);
            t_hw_result r;
            logic [63:0] n, a, b, pf, eaa, ehet, ebb, chi;
            bit zero_seen;
            zero_seen = 0;
            n = 64'(aa) + het + bb;
            r = '0;
            if (n == 0) begin
                r.status = hwcs_pkg::StEmpty;
            end else begin
                a = 2 * 64'(aa) + het;
                b = 2 * 64'(bb) + het;
                pf = (a * 32768) / n;
                eaa = (64 * a * a) / n;
                ehet = (128 * a * b) / n;
                ebb = (64 * b * b) / n;
                chi = chi_term(aa, eaa, zero_seen);
                chi += chi_term(het, ehet, zero_seen);
                chi += chi_term(bb, ebb, zero_seen);
                if (chi > 64'(hwcs_pkg::ChiMax)) chi = 64'(hwcs_pkg::ChiMax);
                r.total = n[TotalW-1:0];
                r.p = pf[FreqW-1:0];
                r.q = FreqW'(65536 - pf);
                r.e_aa = eaa[ExpW-1:0];
                r.e_het = ehet[ExpW-1:0];
                r.e_bb = ebb[ExpW-1:0];
                r.chi = chi[ExpW-1:0];
                r.status = zero_seen ? hwcs_pkg::StZeroExp : hwcs_pkg::StOk;
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_hw_result got);
            t_hw_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    localparam int DogLimit = 5000;
    localparam int Latency  = 66;
    localparam int MaxCount = (1 << CountBits) - 1;

    logic i_clk = 0;
    logic i_rst_n = 0;

    hwcs_in_if  in_ch();
    hwcs_res_if res_ch();

    hardy_weinberg_chi_square u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    hw_scoreboard board = new();
    bit  sending_done = 0;
    bit  hold_long = 0;
    int  idle_cycles = 0;

    initial begin
        in_ch.valid = 0;
        in_ch.count_hom_major = 0;
        in_ch.count_het = 0;
        in_ch.count_hom_minor = 0;
        res_ch.ready = 0;
    end

    // offer one triple, with a random gap first, and wait for its transfer
    task automatic send_counts(int aa, int het, int bb);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.count_hom_major <= aa[CountBits-1:0];
        in_ch.count_het <= het[CountBits-1:0];
        in_ch.count_hom_minor <= bb[CountBits-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_counts(in_ch.count_hom_major, in_ch.count_het, in_ch.count_hom_minor);
        @(negedge i_clk);
    endtask

    // count of mixed magnitude: half the time small, otherwise near the top or full range
    function automatic int rand_count();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(0, 15);
            2: return $urandom_range(0, 1000);
            3: return MaxCount - $urandom_range(0, 15);
            default: return $urandom_range(0, MaxCount);
        endcase
    endfunction

    // stimulus
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // zero total, monomorphic markers, single counts, full scale
        send_counts(0, 0, 0);
        send_counts(1, 0, 0);
        send_counts(0, 1, 0);
        send_counts(0, 0, 1);
        send_counts(MaxCount, 0, 0);
        send_counts(0, MaxCount, 0);
        send_counts(0, 0, MaxCount);
        send_counts(MaxCount, MaxCount, MaxCount);
        send_counts(MaxCount, 0, MaxCount);
        send_counts(MaxCount, 1, 0);
        send_counts(1, 0, MaxCount);
        send_counts(25, 50, 25);
        send_counts(1, 1, 1);
        send_counts(0, 1, 1);
        send_counts(MaxCount, 0, 1);
        send_counts(MaxCount, MaxCount, 0);
        send_counts('h55555, 'hAAAAA, 'h55555);
        send_counts('hAAAAA, 'h55555, 'hAAAAA);
        // long output stall while input keeps offering, so the pipe backs up
        hold_long = 1;
        repeat (120) send_counts($urandom_range(0, MaxCount), rand_count(), rand_count());
        repeat (580) send_counts(rand_count(), rand_count(), rand_count());
        in_ch.valid <= 0;
        sending_done = 1;
    end

    // result side: random pause before each result, one long hold-off counted here
    initial begin
        int gap;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_long) begin
                hold_long = 0;
                res_ch.ready <= 0;
                repeat (300) @(negedge i_clk);
            end
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                res_ch.ready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1;
            do @(posedge i_clk); while (!res_ch.valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            board.check_result({res_ch.total_count, res_ch.freq_major, res_ch.freq_minor,
                                res_ch.expect_hom_major, res_ch.expect_het,
                                res_ch.expect_hom_minor, res_ch.chi_square,
                                res_ch.status});
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= DogLimit) begin
            $display("hardy_weinberg_chi_square_test: errors");
            $finish;
        end
    end

    // end of run: drain the scoreboard, wait on for stray results, then report
    initial begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("hardy_weinberg_chi_square_test: clean");
        end else begin
            $display("hardy_weinberg_chi_square_test: errors");
        end
        $finish;
    end
endmodule
